### hw/rtl/rar_pkg.sv
package rar_pkg;

   // Field widths of the request and response.
   localparam int IN_WIDTH  = 16;
   localparam int NUM_W     = IN_WIDTH;
   localparam int DEN_W     = IN_WIDTH - 1;
   localparam int DW        = 2 * IN_WIDTH;
   localparam int OUT_DEN_W = 2 * IN_WIDTH - 2;
   localparam int CNT_W     = $clog2(DW);

   typedef struct packed {
      logic signed [NUM_W-1:0] first_numerator;
      logic        [DEN_W-1:0] first_denominator;
      logic signed [NUM_W-1:0] second_numerator;
      logic        [DEN_W-1:0] second_denominator;
   } rar_req_type;

   typedef struct packed {
      logic signed [DW-1:0]        sum_numerator;
      logic        [OUT_DEN_W-1:0] sum_denominator;
   } rar_rsp_type;

   // Datapath operations selected by the microcode.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_MUL_AD,
      OP_MUL_CB,
      OP_MUL_BD,
      OP_SIGN,
      OP_HALVE_BOTH,
      OP_COPY,
      OP_HALVE_U,
      OP_GCD_STEP,
      OP_DIV_LOAD_MAG,
      OP_DIV_STEP,
      OP_DIV_LOAD_DEN,
      OP_OUT_SUM,
      OP_OUT_ZERO,
      OP_OUT_ERR
   } op_type;

   // Status from the datapath, used for conditional jumps and output stalls.
   typedef struct packed {
      logic den_zero;
      logic num_zero;
      logic both_even;
      logic u_even;
      logic v_nz;
      logic cnt_last;
      logic out_free;
   } flags_type;

   typedef struct packed {
      logic   busy;
      op_type op;
   } ctl_type;

endpackage

### hw/rtl/rar_dp.sv
module rar_dp
   import rar_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  rar_req_type req_payload,
   input  op_type      op,
   output flags_type   flags,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rar_rsp_type rsp_payload
);

   logic signed [NUM_W-1:0] a_ff, a_in, c_ff, c_in;
   logic        [DEN_W-1:0] b_ff, b_in, d_ff, d_in;
   logic signed [DW-1:0]    prod_ff, prod_in, sum_ff, sum_in;
   logic                    neg_ff, neg_in;
   logic        [DW-1:0]    u_ff, u_in, v_ff, v_in;
   logic        [DW-1:0]    mag_ff, mag_in, den_ff, den_in;
   logic        [DW-1:0]    rem_ff, rem_in, quo_ff, quo_in;
   logic        [CNT_W-1:0] cnt_ff, cnt_in;
   rar_rsp_type             rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic signed [NUM_W-1:0] mul_x, mul_y;
   logic signed [DW-1:0]    mul_p;
   logic        [DW-1:0]    sum_bits, sum_abs;
   logic        [DW:0]      rem_sh, trial;
   logic                    is_out;

   // One shared signed multiplier; denominators enter with a zero sign bit.
   always_comb begin
      unique case (op)
         OP_MUL_AD: begin
            mul_x = a_ff;
            mul_y = $signed({1'b0, d_ff});
         end
         OP_MUL_CB: begin
            mul_x = c_ff;
            mul_y = $signed({1'b0, b_ff});
         end
         default: begin
            mul_x = $signed({1'b0, b_ff});
            mul_y = $signed({1'b0, d_ff});
         end
      endcase
   end

   assign mul_p    = DW'(mul_x) * DW'(mul_y);
   assign sum_bits = sum_ff;
   assign sum_abs  = sum_ff[DW-1] ? -sum_bits : sum_bits;
   assign rem_sh   = {rem_ff, quo_ff[DW-1]};
   assign trial    = rem_sh - {1'b0, u_ff};
   assign is_out   = (op == OP_OUT_SUM) || (op == OP_OUT_ZERO) || (op == OP_OUT_ERR);

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      neg_in   = neg_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      mag_in   = mag_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      rsp_in   = rsp_ff;

      if (start) begin
         a_in = req_payload.first_numerator;
         b_in = req_payload.first_denominator;
         c_in = req_payload.second_numerator;
         d_in = req_payload.second_denominator;
      end

      unique case (op)
         OP_NOP: begin
         end
         OP_MUL_AD: begin
            prod_in = mul_p;
         end
         OP_MUL_CB: begin
            prod_in = mul_p;
            sum_in  = prod_ff;
         end
         OP_MUL_BD: begin
            prod_in = mul_p;
            sum_in  = sum_ff + prod_ff;
         end
         OP_SIGN: begin
            neg_in = sum_ff[DW-1];
            u_in   = sum_abs;
            v_in   = prod_ff;
         end
         OP_HALVE_BOTH: begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
            end
         end
         OP_COPY: begin
            mag_in = u_ff;
            den_in = v_ff;
         end
         OP_HALVE_U: begin
            if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end
         end
         OP_GCD_STEP: begin
            if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff > v_ff) begin
               u_in = v_ff;
               v_in = u_ff - v_ff;
            end else begin
               v_in = v_ff - u_ff;
            end
         end
         OP_DIV_LOAD_MAG: begin
            rem_in = '0;
            quo_in = mag_ff;
            cnt_in = '0;
         end
         OP_DIV_STEP: begin
            if (!trial[DW]) begin
               rem_in = trial[DW-1:0];
               quo_in = {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DW-1:0];
               quo_in = {quo_ff[DW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         OP_DIV_LOAD_DEN: begin
            mag_in = quo_ff;
            rem_in = '0;
            quo_in = den_ff;
            cnt_in = '0;
         end
         OP_OUT_SUM: begin
            rsp_in.sum_numerator   = neg_ff ? -mag_ff : mag_ff;
            rsp_in.sum_denominator = quo_ff[OUT_DEN_W-1:0];
         end
         OP_OUT_ZERO: begin
            rsp_in.sum_numerator   = '0;
            rsp_in.sum_denominator = OUT_DEN_W'(1);
         end
         OP_OUT_ERR: begin
            rsp_in.sum_numerator   = '0;
            rsp_in.sum_denominator = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (is_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      d_ff    <= d_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      neg_ff  <= neg_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      mag_ff  <= mag_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   assign flags.den_zero  = (b_ff == '0) || (d_ff == '0);
   assign flags.num_zero  = (sum_ff == '0);
   assign flags.both_even = !u_ff[0] && !v_ff[0];
   assign flags.u_even    = !u_ff[0];
   assign flags.v_nz      = (v_ff != '0);
   assign flags.cnt_last  = (cnt_ff == CNT_W'(DW - 1));
   assign flags.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // The subtract loop relies on the odd part staying odd.
   a_gcd_u_odd: assert property (@(posedge clock) disable iff (reset)
      op == OP_GCD_STEP |-> u_ff[0])
      else $error("gcd step with even u");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      op == OP_DIV_STEP |-> u_ff != '0)
      else $error("division by zero divisor");

   a_out_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      op == OP_OUT_SUM |-> quo_ff != '0)
      else $error("reduced denominator is zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      is_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before it was taken");
`endif

endmodule

### hw/rtl/rar_seq.sv
module rar_seq
   import rar_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  flags_type flags,
   output ctl_type   ctl
);

   localparam int PC_W = 4;

   typedef enum logic [2:0] {
      C_NEXT,
      C_DEN_ZERO,
      C_NUM_ZERO,
      C_BOTH_EVEN,
      C_U_EVEN,
      C_V_NZ,
      C_CNT_NLAST,
      C_END
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   localparam logic [PC_W-1:0] P_START  = 4'd0;
   localparam logic [PC_W-1:0] P_TWOS   = 4'd4;
   localparam logic [PC_W-1:0] P_UEVEN  = 4'd6;
   localparam logic [PC_W-1:0] P_GCD    = 4'd7;
   localparam logic [PC_W-1:0] P_DIV1   = 4'd9;
   localparam logic [PC_W-1:0] P_DIV2   = 4'd11;
   localparam logic [PC_W-1:0] P_ZERO   = 4'd13;
   localparam logic [PC_W-1:0] P_ERR    = 4'd14;

   // The program: a jump is taken when its condition holds, else the next step follows.
   localparam ucode_type ROM [2**PC_W] = '{
      '{OP_MUL_AD,       C_DEN_ZERO,  P_ERR},
      '{OP_MUL_CB,       C_NEXT,      P_START},
      '{OP_MUL_BD,       C_NEXT,      P_START},
      '{OP_SIGN,         C_NUM_ZERO,  P_ZERO},
      '{OP_HALVE_BOTH,   C_BOTH_EVEN, P_TWOS},
      '{OP_COPY,         C_NEXT,      P_START},
      '{OP_HALVE_U,      C_U_EVEN,    P_UEVEN},
      '{OP_GCD_STEP,     C_V_NZ,      P_GCD},
      '{OP_DIV_LOAD_MAG, C_NEXT,      P_START},
      '{OP_DIV_STEP,     C_CNT_NLAST, P_DIV1},
      '{OP_DIV_LOAD_DEN, C_NEXT,      P_START},
      '{OP_DIV_STEP,     C_CNT_NLAST, P_DIV2},
      '{OP_OUT_SUM,      C_END,       P_START},
      '{OP_OUT_ZERO,     C_END,       P_START},
      '{OP_OUT_ERR,      C_END,       P_START},
      '{OP_NOP,          C_END,       P_START}
   };

   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       word;
   logic            is_out, exec, take;

   assign word   = ROM[pc_ff];
   assign is_out = (word.op == OP_OUT_SUM) || (word.op == OP_OUT_ZERO)
                   || (word.op == OP_OUT_ERR);
   // An output step waits while the response register is still occupied.
   assign exec   = busy_ff && (!is_out || flags.out_free);

   always_comb begin
      unique case (word.cond)
         C_NEXT:      take = 1'b0;
         C_DEN_ZERO:  take = flags.den_zero;
         C_NUM_ZERO:  take = flags.num_zero;
         C_BOTH_EVEN: take = flags.both_even;
         C_U_EVEN:    take = flags.u_even;
         C_V_NZ:      take = flags.v_nz;
         C_CNT_NLAST: take = !flags.cnt_last;
         C_END:       take = 1'b0;
         default:     take = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = P_START;
      end else if (exec) begin
         if (word.cond == C_END) begin
            busy_in = 1'b0;
         end else if (take) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= P_START;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign ctl.busy = busy_ff;
   assign ctl.op   = exec ? word.op : OP_NOP;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("request started while busy");

   a_idle_nop: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> ctl.op == OP_NOP)
      else $error("operation issued while idle");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      exec && word.cond == C_END |=> !busy_ff)
      else $error("sequencer still busy after final step");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !exec |=> busy_ff && $stable(pc_ff))
      else $error("step counter moved during an output stall");
`endif

endmodule

### hw/rtl/rational_add_reduce.sv
// Channel   Ports                                  Direction  Moves
// request   req_valid, req_ready, req_payload      in         two fractions a/b and c/d
// response  rsp_valid, rsp_ready, rsp_payload      out        reduced sum n/m
//
// The binary gcd does one halving or one subtraction per cycle, and the two restoring
// divisions each run over the full 32-bit width. A zero denominator ends early in the
// error response, and a zero sum ends early in the zero response.
// Reset is synchronous and active high; it clears the sequencer and the response valid.
// A new request is accepted once the previous one has reached the response register; if
// that response is still not taken, the next request stalls at its final step.
module rational_add_reduce
   import rar_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rar_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rar_rsp_type rsp_payload
);

   ctl_type   ctl;
   flags_type flags;
   logic      start;

   // The block works on one request at a time; it takes a new one only when idle.
   assign req_ready = !ctl.busy;
   assign start     = req_valid && req_ready;

   // The sequencer steps through a small microprogram: three multiplies, sign
   // handling, removal of common factors of two, the odd gcd, then two divisions.
   rar_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .ctl   (ctl)
   );

   // The datapath holds the operands, the gcd working pair and the divider, and
   // owns the response register.
   rar_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .op          (ctl.op),
      .flags       (flags),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
